// ===== sv/mavt_pkg.sv =====
// shared types, constants and helpers for the motion activity variance tracker
// no dependencies
package mavt_pkg;

  localparam int unsigned QUO_W = 16;

  localparam logic [7:0]  CNT_SAT      = 8'd255;
  localparam logic [15:0] IDLE_STEP    = 16'd15;
  localparam logic [15:0] IDLE_SAT     = 16'hFFFF;
  localparam logic [15:0] VAR_SAT      = 16'hFFFF;
  localparam int unsigned MIN_VAR_FILL = 2;

  localparam logic OP_SAMPLE    = 1'b0;
  localparam logic OP_HOUR_CLR  = 1'b1;

  localparam logic CFG_ACCEL_PRESENT = 1'b0;
  localparam logic CFG_INACT_LIMIT   = 1'b1;

  localparam logic        ACCEL_PRESENT_RST = 1'b1;
  localparam logic [15:0] INACT_LIMIT_RST   = 16'd60;

  // divider steps: one overflow check then QUO_W quotient bits
  localparam logic [4:0] DIV_FIRST_STEP = 5'(QUO_W);

  typedef struct packed {
    logic               op;
    logic               wake_event;
    logic               sleep_flag;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic [15:0] magnitude;
    logic [15:0] variance;
    logic        moving;
    logic [15:0] idle_minutes;
    logic [7:0]  epoch_moves;
    logic [7:0]  hourly_moves;
  } out_item_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_stat_t;

  // absolute value of a two's complement axis, most negative gives 32768
  function automatic logic [16:0] axis_abs(input logic [15:0] v);
    logic [16:0] r;
    if (v[15]) begin
      r = 17'h10000 - {1'b0, v};
    end else begin
      r = {1'b0, v};
    end
    return r;
  endfunction

endpackage

// ===== sv/mavt_div.sv =====
// iterative restoring divider, one quotient bit per cycle, saturation flag
// depends on mavt_pkg
module mavt_div
  import mavt_pkg::*;
#(
  parameter int unsigned DVD_W = 37,
  parameter int unsigned DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_stat_t        stat
);

  logic [DVD_W-1:0] rem_r;
  logic [DVD_W-1:0] dsr_r;
  logic [4:0]       step_r;
  logic             run_r;
  logic             done_r;
  logic             ovf_r;
  logic [QUO_W-1:0] quo_r;
  logic             ge;

  // shared compare and subtract
  assign ge = (rem_r >= dsr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        rem_r  <= dividend;
        dsr_r  <= DVD_W'(divisor) << QUO_W;
        step_r <= DIV_FIRST_STEP;
        ovf_r  <= 1'b0;
        quo_r  <= '0;
      end else if (run_r) begin
        dsr_r <= dsr_r >> 1;
        if (step_r == DIV_FIRST_STEP) begin
          // quotient would not fit
          if (ge) begin
            ovf_r  <= 1'b1;
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end
          step_r <= step_r - 5'd1;
        end else begin
          if (ge) begin
            rem_r <= rem_r - dsr_r;
          end
          quo_r <= {quo_r[QUO_W-2:0], ge};
          if (step_r == 5'd0) begin
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end else begin
            step_r <= step_r - 5'd1;
          end
        end
      end
    end
  end

  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign stat.quo  = quo_r;

endmodule

// ===== sv/motion_activity_variance_tracker.sv =====
// flow: an hourly clear, no accelerometer or fewer than two ring entries go from the accepting
// edge straight to the output state; any other sample first runs a sum pass over the ring, the
// mean division, a squared-deviation pass and the variance division
// throughput: one item at a time, in_ready only while idle, so a sample holds the block
// through both ring passes and both divisions on the shared divider, plus any output stall
// reset: synchronous active low, clears counters, ring fill and pointers; ring data unset
module motion_activity_variance_tracker
  import mavt_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned A_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned N_W   = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W = 16 + N_W;
  localparam int unsigned SQ_W  = 32 + N_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_MEAN = 3'd2;
  localparam logic [2:0] ST_SQ   = 3'd3;
  localparam logic [2:0] ST_VAR  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic             accel_r;
  logic [15:0]      limit_r;
  logic [A_W-1:0]   wpos_r;
  logic [N_W-1:0]   fill_r, fill_nxt;
  logic [15:0]      idle_r, idle_nxt;
  logic             active_r, active_nxt;
  logic [7:0]       epoch_r, epoch_nxt;
  logic [7:0]       hour_r, hour_nxt;
  logic [15:0]      last_mag_r;
  logic [15:0]      last_var_r;
  logic [15:0]      mean_r;
  logic [N_W-1:0]   idx_r;
  logic             rd_vld_r, d_vld_r, p_vld_r;
  logic [15:0]      mem_q_r;
  logic [15:0]      d_r;
  logic [31:0]      prod_r;
  logic [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]  sq_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic [15:0] ring_mem [RING_DEPTH];

  logic             in_fire;
  logic             issuing;
  logic [15:0]      mag;
  logic [16:0]      idle_sum;
  logic             div_start;
  logic [SQ_W-1:0]  div_dvd;
  div_stat_t        div_stat;
  logic             out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign issuing  = (idx_r < fill_r);
  assign out_free = !out_valid_r || out_ready;

  assign mag = 16'(18'(axis_abs(in_data.accel_x)) + 18'(axis_abs(in_data.accel_y))
                 + 18'(axis_abs(in_data.accel_z)));
  assign idle_sum = {1'b0, idle_r} + {1'b0, IDLE_STEP};

  // flag and counter update for an accepted item (sample or hourly clear)
  always_comb begin
    active_nxt = active_r;
    idle_nxt   = idle_r;
    epoch_nxt  = epoch_r;
    hour_nxt   = hour_r;
    fill_nxt   = fill_r;
    if (in_data.op == OP_HOUR_CLR) begin
      hour_nxt = '0;
    end else if (!accel_r) begin
      active_nxt = 1'b0;
    end else begin
      if (in_data.wake_event) begin
        active_nxt = 1'b1;
        idle_nxt   = '0;
        if (epoch_r != CNT_SAT) epoch_nxt = epoch_r + 8'd1;
        if (hour_r != CNT_SAT)  hour_nxt  = hour_r + 8'd1;
      end else if (in_data.sleep_flag) begin
        idle_nxt = idle_sum[16] ? IDLE_SAT : idle_sum[15:0];
        if (idle_nxt >= limit_r) active_nxt = 1'b0;
      end
      if (fill_r != N_W'(RING_DEPTH)) fill_nxt = fill_r + N_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_dvd   = sq_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.op == OP_SAMPLE && accel_r && fill_nxt >= N_W'(MIN_VAR_FILL)) begin
            state_nxt = ST_SUM;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_SUM: begin
        div_dvd = SQ_W'(sum_r);
        if (!issuing && !rd_vld_r) begin
          div_start = 1'b1;
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (div_stat.done) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        if (!issuing && !rd_vld_r && !d_vld_r && !p_vld_r) begin
          div_start = 1'b1;
          state_nxt = ST_VAR;
        end
      end
      ST_VAR: begin
        if (div_stat.done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  mavt_div #(
    .DVD_W(SQ_W),
    .DVS_W(N_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (fill_r),
    .stat    (div_stat)
  );

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (in_fire && in_data.op == OP_SAMPLE && accel_r) begin
      ring_mem[wpos_r] <= mag;
    end
    mem_q_r <= ring_mem[idx_r[A_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      accel_r     <= ACCEL_PRESENT_RST;
      limit_r     <= INACT_LIMIT_RST;
      wpos_r      <= '0;
      fill_r      <= '0;
      idle_r      <= '0;
      active_r    <= 1'b0;
      epoch_r     <= '0;
      hour_r      <= '0;
      last_mag_r  <= '0;
      last_var_r  <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      d_vld_r     <= 1'b0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_ACCEL_PRESENT: accel_r <= cfg_wdata[0];
          CFG_INACT_LIMIT:   limit_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (in_fire) begin
        active_r <= active_nxt;
        idle_r   <= idle_nxt;
        epoch_r  <= epoch_nxt;
        hour_r   <= hour_nxt;
        fill_r   <= fill_nxt;
        idx_r    <= '0;
        sum_r    <= '0;
        sq_r     <= '0;
        if (in_data.op == OP_SAMPLE) begin
          if (!accel_r) begin
            last_mag_r <= '0;
            last_var_r <= '0;
          end else begin
            last_mag_r <= mag;
            last_var_r <= '0;
            wpos_r <= (wpos_r == A_W'(RING_DEPTH - 1)) ? '0 : wpos_r + A_W'(1);
          end
        end
      end

      // ring pass pipeline: read, deviation, square, accumulate (sum pass: read, accumulate)
      rd_vld_r <= (state_r == ST_SUM || state_r == ST_SQ) && issuing;
      if ((state_r == ST_SUM || state_r == ST_SQ) && issuing) begin
        idx_r <= idx_r + N_W'(1);
      end
      if (state_r == ST_SUM && rd_vld_r) begin
        sum_r <= sum_r + SUM_W'(mem_q_r);
      end
      if (state_r == ST_MEAN && div_stat.done) begin
        mean_r <= div_stat.quo;
        idx_r  <= '0;
      end
      d_vld_r <= (state_r == ST_SQ) && rd_vld_r;
      d_r     <= (mem_q_r >= mean_r) ? (mem_q_r - mean_r) : (mean_r - mem_q_r);
      p_vld_r <= d_vld_r;
      prod_r  <= d_r * d_r;
      if (p_vld_r) begin
        sq_r <= sq_r + SQ_W'(prod_r);
      end
      if (state_r == ST_VAR && div_stat.done) begin
        last_var_r <= div_stat.ovf ? VAR_SAT : div_stat.quo;
      end

      // output register, one result per item
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_data_r.magnitude     <= accel_r ? last_mag_r : '0;
      out_data_r.variance      <= accel_r ? last_var_r : '0;
      out_data_r.moving        <= accel_r ? active_r : 1'b0;
      out_data_r.idle_minutes  <= idle_r;
      out_data_r.epoch_moves   <= epoch_r;
      out_data_r.hourly_moves  <= hour_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= N_W'(RING_DEPTH))
    else $error("ring fill count above depth");

  a_var_short: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r < N_W'(MIN_VAR_FILL)) |-> (last_var_r == '0))
    else $error("variance nonzero with fewer than two samples");

  a_clear_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.op == OP_HOUR_CLR) |=> (state_r == ST_OUT && hour_r == '0))
    else $error("hourly clear did not go straight to output");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result shown outside output state");
`endif

endmodule

// ===== verif/tb_motion_activity_variance_tracker.sv =====
`timescale 1ns / 1ps
// self-checking bench for motion_activity_variance_tracker: directed table, random phases
// and a wake-counter saturation run, every report checked against a typed row or an in-bench
// tracker model; depends on mavt_pkg and the motion_activity_variance_tracker rtl
module tb_motion_activity_variance_tracker;
  import mavt_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RING_N       = 16;
  localparam int IDLE_PCT     = 19;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 120;
  localparam int RAND_PHASES  = 11;
  localparam int PHASE_ITEMS  = 120;
  localparam int WAKE_RUN     = 260;
  localparam int SLEEP_RUN    = 100;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [1:0] {ROW_PRED, ROW_TYPED, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    in_item_t    item;
    out_item_t   want;
    logic        reg_idx;
    logic [15:0] reg_val;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  motion_activity_variance_tracker #(
    .RING_DEPTH(RING_N)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // tracker model state
  logic [15:0] trk_ring [RING_N];
  logic [3:0]  trk_wpos;
  logic [4:0]  trk_fill;
  logic [15:0] trk_idle;
  logic        trk_active;
  logic [7:0]  trk_epoch;
  logic [7:0]  trk_hour;
  logic [15:0] trk_mag;
  logic [15:0] trk_var;
  logic        trk_present;
  logic [15:0] trk_limit;

  out_item_t report_q[$];
  dir_row_t  dir_tab[$];
  int        mismatches = 0;
  int        reports_seen = 0;
  int        items_sent = 0;
  int        hold_reqs = 0;
  bit        calm = 1'b0;
  int        axis_mode = 0;

  function automatic void tracker_reset();
    foreach (trk_ring[i]) trk_ring[i] = '0;
    trk_wpos    = '0;
    trk_fill    = '0;
    trk_idle    = '0;
    trk_active  = 1'b0;
    trk_epoch   = '0;
    trk_hour    = '0;
    trk_mag     = '0;
    trk_var     = '0;
    trk_present = ACCEL_PRESENT_RST;
    trk_limit   = INACT_LIMIT_RST;
  endfunction

  function automatic logic [16:0] axis_mag(logic signed [15:0] a);
    logic signed [17:0] w;
    w = a;
    if (w < 0) w = -w;
    return w[16:0];
  endfunction

  // exact population variance: floor mean, floor division, saturated
  function automatic logic [15:0] ring_spread();
    longint unsigned total, sq, mean, dev, v;
    int unsigned n;
    n = trk_fill;
    if (n < MIN_VAR_FILL) return 16'd0;
    total = 0;
    sq = 0;
    for (int i = 0; i < n; i++) total += trk_ring[i];
    mean = total / n;
    for (int i = 0; i < n; i++) begin
      dev = (trk_ring[i] >= mean) ? trk_ring[i] - mean : mean - trk_ring[i];
      sq += dev * dev;
    end
    v = sq / n;
    return (v > 64'd65535) ? VAR_SAT : v[15:0];
  endfunction

  function automatic out_item_t tracker_step(in_item_t it);
    out_item_t   r;
    logic [17:0] mag_sum;
    logic [16:0] idle_next;
    if (it.op == OP_HOUR_CLR) begin
      trk_hour = '0;
    end else if (!trk_present) begin
      trk_active = 1'b0;
      trk_mag    = '0;
      trk_var    = '0;
    end else begin
      // wake wins over sleep
      if (it.wake_event) begin
        trk_active = 1'b1;
        trk_idle   = '0;
        if (trk_epoch != CNT_SAT) trk_epoch++;
        if (trk_hour != CNT_SAT) trk_hour++;
      end else if (it.sleep_flag) begin
        idle_next = {1'b0, trk_idle} + IDLE_STEP;
        trk_idle = (idle_next > 17'h0FFFF) ? IDLE_SAT : idle_next[15:0];
        if (trk_idle >= trk_limit) trk_active = 1'b0;
      end
      mag_sum = axis_mag(it.accel_x) + axis_mag(it.accel_y) + axis_mag(it.accel_z);
      trk_mag = mag_sum[15:0];
      trk_ring[trk_wpos] = trk_mag;
      trk_wpos = trk_wpos + 4'd1;
      if (trk_fill < RING_N) trk_fill++;
      trk_var = ring_spread();
    end
    r.magnitude     = trk_present ? trk_mag : '0;
    r.variance      = trk_present ? trk_var : '0;
    r.moving        = trk_present ? trk_active : 1'b0;
    r.idle_minutes  = trk_idle;
    r.epoch_moves   = trk_epoch;
    r.hourly_moves  = trk_hour;
    return r;
  endfunction

  function automatic void check_report(out_item_t got, out_item_t want);
    string bad;
    bad = "";
    if (got.magnitude !== want.magnitude) bad = {bad, " magnitude"};
    if (got.variance !== want.variance) bad = {bad, " variance"};
    if (got.moving !== want.moving) bad = {bad, " moving"};
    if (got.idle_minutes !== want.idle_minutes) bad = {bad, " idle_minutes"};
    if (got.epoch_moves !== want.epoch_moves) bad = {bad, " epoch_moves"};
    if (got.hourly_moves !== want.hourly_moves) bad = {bad, " hourly_moves"};
    if (bad != "") begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("report %0d bad%s: exp mag=%0d var=%0d act=%0b idle=%0d ep=%0d hr=%0d",
                 reports_seen, bad, want.magnitude, want.variance, want.moving,
                 want.idle_minutes, want.epoch_moves, want.hourly_moves);
        $display("  got mag=%0d var=%0d act=%0b idle=%0d ep=%0d hr=%0d", got.magnitude,
                 got.variance, got.moving, got.idle_minutes, got.epoch_moves,
                 got.hourly_moves);
      end
    end
  endfunction

  function automatic void add_item(row_kind_t kind, logic [2:0] flags, logic [15:0] x,
                                   logic [15:0] y, logic [15:0] z, out_item_t want = '0);
    dir_row_t row;
    row.kind = kind;
    {row.item.op, row.item.wake_event, row.item.sleep_flag} = flags;
    row.item.accel_x = x;
    row.item.accel_y = y;
    row.item.accel_z = z;
    row.want = want;
    row.reg_idx = 1'b0;
    row.reg_val = '0;
    dir_tab.push_back(row);
  endfunction

  function automatic void add_reg(logic idx, logic [15:0] val);
    dir_row_t row;
    row.kind = ROW_CFG;
    row.item = '0;
    row.want = '0;
    row.reg_idx = idx;
    row.reg_val = val;
    dir_tab.push_back(row);
  endfunction

  function automatic logic [15:0] rand_axis(int mode);
    case (mode)
      0: return 16'($urandom_range(16'hFFFF));
      1: return 16'($urandom_range(200)) - 16'd100;  // near zero, moderate variance
      2: return 16'd20000 + 16'($urandom_range(60));  // large but tightly grouped
      default: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.op         = ($urandom_range(99) < 5) ? OP_HOUR_CLR : OP_SAMPLE;
    it.wake_event = ($urandom_range(99) < 25);
    it.sleep_flag = ($urandom_range(99) < 55);
    it.accel_x    = rand_axis(axis_mode);
    it.accel_y    = rand_axis(axis_mode);
    it.accel_z    = rand_axis(axis_mode);
    return it;
  endfunction

  // hold valid until the transfer, then record what the tracker should report
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    begin
      out_item_t pred;
      pred = tracker_step(it);
      report_q.push_back(typed ? want : pred);
    end
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ACCEL_PRESENT) trk_present = val[0];
    else trk_limit = val;
    @(posedge clk);
  endtask

  // receiver: random stalls, plus long hold-offs on request
  initial begin : sink
    int holds_done;
    int hold_left;
    holds_done = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done < hold_reqs) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : report_mon
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      reports_seen++;
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected report %0d: mag=%0d var=%0d", reports_seen,
                   out_data.magnitude, out_data.variance);
      end else begin
        want = report_q.pop_front();
        check_report(out_data, want);
      end
    end
  end

  initial begin : stim
    logic [15:0] lim;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = 1'b0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    tracker_reset();

    // directed rows
    add_item(ROW_TYPED, 3'b100, 16'h0000, 16'h0000, 16'h0000,
             '{16'd0, 16'd0, 1'b0, 16'd0, 8'd0, 8'd0});
    add_item(ROW_TYPED, 3'b000, 16'h8000, 16'h0000, 16'h0000,
             '{16'd32768, 16'd0, 1'b0, 16'd0, 8'd0, 8'd0});
    // 3 x 32767 wraps to 32765; ring {32768, 32765} gives variance 2
    add_item(ROW_TYPED, 3'b010, 16'h7FFF, 16'h7FFF, 16'h7FFF,
             '{16'd32765, 16'd2, 1'b1, 16'd0, 8'd1, 8'd1});
    add_item(ROW_PRED, 3'b011, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // wake beats sleep
    repeat (4) add_item(ROW_PRED, 3'b001, 16'd12, 16'hFFF0, 16'd3);
    add_item(ROW_PRED, 3'b000, 16'h8000, 16'h8000, 16'h8000);
    add_item(ROW_PRED, 3'b111, 16'hFFFF, 16'h7FFF, 16'h8000);  // clear ignores flags and axes
    add_reg(CFG_INACT_LIMIT, 16'd0);
    add_item(ROW_PRED, 3'b010, 16'd100, 16'd200, 16'd300);
    add_item(ROW_PRED, 3'b001, 16'd101, 16'd200, 16'd300);
    add_reg(CFG_INACT_LIMIT, 16'hFFFF);
    add_item(ROW_PRED, 3'b010, 16'd5, 16'd5, 16'd5);
    add_item(ROW_PRED, 3'b001, 16'd6, 16'd5, 16'd5);
    add_reg(CFG_ACCEL_PRESENT, 16'd0);
    add_item(ROW_PRED, 3'b010, 16'h1234, 16'h8000, 16'h7FFF);
    add_item(ROW_PRED, 3'b100, 16'h0000, 16'h0000, 16'h0000);
    add_reg(CFG_ACCEL_PRESENT, 16'd1);
    add_item(ROW_PRED, 3'b000, 16'h0000, 16'h0000, 16'h0000);
    add_reg(CFG_INACT_LIMIT, INACT_LIMIT_RST);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[k]) begin
      case (dir_tab[k].kind)
        ROW_CFG:   write_reg(dir_tab[k].reg_idx, dir_tab[k].reg_val);
        ROW_TYPED: send_item(dir_tab[k].item, 1'b1, dir_tab[k].want);
        default:   send_item(dir_tab[k].item, 1'b0, '0);
      endcase
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 6)
        0: lim = 16'd0;
        1: lim = 16'hFFFF;
        2: lim = INACT_LIMIT_RST;
        3: lim = 16'd15;
        default: lim = 16'($urandom_range(16'hFFFF));
      endcase
      write_reg(CFG_ACCEL_PRESENT, (ph % 4 == 3) ? 16'd0 : 16'd1);
      write_reg(CFG_INACT_LIMIT, lim);
      calm = (ph == 2);
      if (ph == 4) hold_reqs++;  // receiver backs off while items keep coming
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 20 == 0) axis_mode = $urandom_range(3);
        send_item(random_item(), 1'b0, '0);
      end
    end

    // saturate the wake counters, then a run of sleep samples
    write_reg(CFG_ACCEL_PRESENT, 16'd1);
    write_reg(CFG_INACT_LIMIT, 16'hFFFF);
    calm = 1'b1;
    for (int n = 0; n < WAKE_RUN + SLEEP_RUN; n++) begin
      in_item_t it;
      if (n % 20 == 0) axis_mode = $urandom_range(3);
      it = random_item();
      it.op = OP_SAMPLE;
      it.wake_event = (n < WAKE_RUN);
      it.sleep_flag = (n >= WAKE_RUN) || it.sleep_flag;
      send_item(it, 1'b0, '0);
    end
    calm = 1'b0;

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("%0d items sent, %0d reports checked: directed corners, %0d register phases,",
             items_sent, reports_seen, RAND_PHASES);
    $display("receiver hold-off, wake counter saturation and a long sleep run");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #(40_000_000);
    $display("timeout with %0d reports outstanding", report_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
